// File: rtl/pmvo_pkg.sv
`default_nettype none
package pmvo_pkg;

  localparam int MAX_VERTEX_COUNT = 16;
  localparam int MAX_EDGE_COUNT   = 256;

  localparam int VTX_W   = 5;
  localparam int WGT_W   = 10;
  localparam int IDX_W   = $clog2(MAX_VERTEX_COUNT);
  localparam int ADDR_W  = $clog2(MAX_EDGE_COUNT);
  localparam int FILL_W  = ADDR_W + 1;
  localparam int EDGE_W  = 2 * VTX_W + WGT_W;

  localparam logic [WGT_W-1:0] UNREACHED = WGT_W'(1000);
  localparam logic [VTX_W-1:0] VCOUNT_RESET = VTX_W'(10);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_INIT,
    ST_SCAN,
    ST_EMIT,
    ST_RELAX,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic store_edge;
    logic init_run;
    logic scan_step;
    logic emit;
    logic relax_issue;
    logic clear_fill;
  } pmvo_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic scan_done;
    logic relax_done;
    logic round_last;
    logic out_busy;
  } pmvo_status_t;

endpackage
`default_nettype wire

// File: rtl/pmvo_ctrl.sv
`default_nettype none
module pmvo_ctrl (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  input  wire                    last_edge,
  output logic                   in_stall,
  input  wire pmvo_pkg::pmvo_status_t status,
  output pmvo_pkg::pmvo_cmd_t    cmd
);

  pmvo_pkg::state_t state;
  pmvo_pkg::state_t state_next;
  logic             in_accept;

  assign in_accept = in_valid && (state == pmvo_pkg::ST_LOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pmvo_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pmvo_pkg::ST_LOAD: begin
        if (in_accept && last_edge) state_next = pmvo_pkg::ST_INIT;
      end
      pmvo_pkg::ST_INIT: begin
        state_next = status.n_zero ? pmvo_pkg::ST_LOAD : pmvo_pkg::ST_SCAN;
      end
      pmvo_pkg::ST_SCAN: begin
        if (status.scan_done) state_next = pmvo_pkg::ST_EMIT;
      end
      pmvo_pkg::ST_EMIT: begin
        if (!status.out_busy) begin
          state_next = status.round_last ? pmvo_pkg::ST_LOAD : pmvo_pkg::ST_RELAX;
        end
      end
      pmvo_pkg::ST_RELAX: begin
        if (status.relax_done) state_next = pmvo_pkg::ST_DRAIN;
      end
      pmvo_pkg::ST_DRAIN: begin
        state_next = pmvo_pkg::ST_SCAN;
      end
      default: state_next = pmvo_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    in_stall        = (state != pmvo_pkg::ST_LOAD);
    cmd             = '0;
    cmd.store_edge  = in_accept;
    unique case (state)
      pmvo_pkg::ST_INIT: begin
        cmd.init_run   = 1'b1;
        cmd.clear_fill = status.n_zero;
      end
      pmvo_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      pmvo_pkg::ST_EMIT: begin
        cmd.emit       = !status.out_busy;
        cmd.clear_fill = !status.out_busy && status.round_last;
      end
      pmvo_pkg::ST_RELAX: begin
        cmd.relax_issue = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/pmvo_dpath.sv
`default_nettype none
module pmvo_dpath (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_write,
  input  wire  [pmvo_pkg::VTX_W-1:0]        cfg_data,
  input  wire  [pmvo_pkg::VTX_W-1:0]        edge_from,
  input  wire  [pmvo_pkg::VTX_W-1:0]        edge_to,
  input  wire  [pmvo_pkg::WGT_W-1:0]        edge_weight,
  input  wire pmvo_pkg::pmvo_cmd_t          cmd,
  output pmvo_pkg::pmvo_status_t            status,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic [pmvo_pkg::VTX_W-1:0]        vertex,
  output logic [pmvo_pkg::WGT_W-1:0]        join_weight,
  output logic                              last_vertex
);

  localparam int NV = pmvo_pkg::MAX_VERTEX_COUNT;

  logic [pmvo_pkg::VTX_W-1:0]  vertex_count;
  logic [pmvo_pkg::VTX_W-1:0]  n_eff;
  logic [pmvo_pkg::VTX_W-1:0]  n_minus1;

  logic [pmvo_pkg::EDGE_W-1:0] edge_mem [pmvo_pkg::MAX_EDGE_COUNT];
  logic [pmvo_pkg::EDGE_W-1:0] rd_data;
  logic                        rd_valid;
  logic [pmvo_pkg::FILL_W-1:0] fill;
  logic [pmvo_pkg::ADDR_W-1:0] raddr;

  logic [pmvo_pkg::WGT_W-1:0]  distance [NV];
  logic [NV-1:0]               in_tree;

  logic [pmvo_pkg::IDX_W-1:0]  scan_idx;
  logic [pmvo_pkg::IDX_W-1:0]  best_idx;
  logic [pmvo_pkg::WGT_W-1:0]  best_dist;
  logic                        found;
  logic                        candidate;
  logic [pmvo_pkg::IDX_W-1:0]  round;

  logic [pmvo_pkg::VTX_W-1:0]  ea;
  logic [pmvo_pkg::VTX_W-1:0]  eb;
  logic [pmvo_pkg::WGT_W-1:0]  ew;
  logic [pmvo_pkg::VTX_W-1:0]  u1;
  logic                        ends_ok;
  logic [NV-1:0]               lower;

  assign n_eff    = (vertex_count > pmvo_pkg::VTX_W'(NV)) ? pmvo_pkg::VTX_W'(NV)
                                                          : vertex_count;
  assign n_minus1 = n_eff - pmvo_pkg::VTX_W'(1);

  assign status.n_zero     = (n_eff == '0);
  assign status.scan_done  = ({1'b0, scan_idx} == n_minus1);
  assign status.relax_done = ({1'b0, raddr} == fill - pmvo_pkg::FILL_W'(1));
  assign status.round_last = ({1'b0, round} == n_minus1);
  assign status.out_busy   = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= pmvo_pkg::VCOUNT_RESET;
    end else if (cfg_write) begin
      vertex_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_edge && !fill[pmvo_pkg::ADDR_W]) begin
      edge_mem[fill[pmvo_pkg::ADDR_W-1:0]] <= {edge_from, edge_to, edge_weight};
    end
    rd_data <= edge_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.relax_issue;
      if (cmd.clear_fill) begin
        fill <= '0;
      end else if (cmd.store_edge && !fill[pmvo_pkg::ADDR_W]) begin
        fill <= fill + pmvo_pkg::FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      raddr <= '0;
    end else if (cmd.relax_issue) begin
      raddr <= raddr + pmvo_pkg::ADDR_W'(1);
    end
  end

  assign candidate = !in_tree[scan_idx] && (!found || distance[scan_idx] < best_dist);

  always_ff @(posedge clk) begin
    if (cmd.init_run || cmd.emit) begin
      scan_idx <= '0;
      found    <= 1'b0;
    end else if (cmd.scan_step) begin
      scan_idx <= scan_idx + pmvo_pkg::IDX_W'(1);
      if (candidate) begin
        best_idx  <= scan_idx;
        best_dist <= distance[scan_idx];
        found     <= 1'b1;
      end
    end
    if (cmd.init_run) begin
      round <= '0;
    end else if (cmd.emit) begin
      round <= round + pmvo_pkg::IDX_W'(1);
    end
  end

  assign ea      = rd_data[pmvo_pkg::EDGE_W-1 -: pmvo_pkg::VTX_W];
  assign eb      = rd_data[pmvo_pkg::WGT_W +: pmvo_pkg::VTX_W];
  assign ew      = rd_data[pmvo_pkg::WGT_W-1:0];
  assign u1      = {1'b0, best_idx} + pmvo_pkg::VTX_W'(1);
  assign ends_ok = (ea != '0) && (ea <= n_eff) && (eb != '0) && (eb <= n_eff);

  always_comb begin
    for (int k = 0; k < NV; k++) begin
      lower[k] = rd_valid && ends_ok && !in_tree[k] && (ew < distance[k]) &&
                 (((ea == u1) && (eb == pmvo_pkg::VTX_W'(k + 1))) ||
                  ((ea != u1) && (eb == u1) && (ea == pmvo_pkg::VTX_W'(k + 1))));
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NV; k++) begin
      if (cmd.init_run) begin
        distance[k] <= (k == 0) ? '0 : pmvo_pkg::UNREACHED;
        in_tree[k]  <= 1'b0;
      end else begin
        if (lower[k]) distance[k] <= ew;
        if (cmd.emit && (best_idx == pmvo_pkg::IDX_W'(k))) in_tree[k] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      vertex      <= u1;
      join_weight <= best_dist;
      last_vertex <= status.round_last;
    end
  end

endmodule
`default_nettype wire

// File: rtl/prim_mst_vertex_order.sv
// Channel  Handshake            Payload
// in       in_valid/in_stall    edge_from, edge_to, edge_weight, last_edge
// out      out_valid/out_stall  vertex, join_weight, last_vertex
// cfg      cfg_write            cfg_data (vertex_count)
//
// Edges load at one per cycle into the edge RAM while in_stall is low; a run starts after last_edge.
// A run with n vertices has n rounds: each round scans n distances,
// then, in all rounds but the last, streams every stored edge through the RAM read port.
// rst is synchronous: clears control, the edge count, and sets vertex_count to 10.
// out_stall holds a pending result; the run waits only when a new one is ready.
`default_nettype none
module prim_mst_vertex_order (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         cfg_write,
  input  wire  [pmvo_pkg::VTX_W-1:0]  cfg_data,
  input  wire                         in_valid,
  output logic                        in_stall,
  input  wire  [pmvo_pkg::VTX_W-1:0]  edge_from,
  input  wire  [pmvo_pkg::VTX_W-1:0]  edge_to,
  input  wire  [pmvo_pkg::WGT_W-1:0]  edge_weight,
  input  wire                         last_edge,
  output logic                        out_valid,
  input  wire                         out_stall,
  output logic [pmvo_pkg::VTX_W-1:0]  vertex,
  output logic [pmvo_pkg::WGT_W-1:0]  join_weight,
  output logic                        last_vertex
);

  pmvo_pkg::pmvo_cmd_t    cmd;
  pmvo_pkg::pmvo_status_t status;

  pmvo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_edge (last_edge),
    .in_stall  (in_stall),
    .status    (status),
    .cmd       (cmd)
  );

  pmvo_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .edge_from   (edge_from),
    .edge_to     (edge_to),
    .edge_weight (edge_weight),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .vertex      (vertex),
    .join_weight (join_weight),
    .last_vertex (last_vertex)
  );

endmodule
`default_nettype wire

// File: tb/tb_prim_mst_vertex_order.sv
`timescale 1ns / 100ps
module tb_prim_mst_vertex_order;

  localparam int SETTLE_CYCLES =
    pmvo_pkg::MAX_VERTEX_COUNT * (pmvo_pkg::MAX_VERTEX_COUNT + pmvo_pkg::MAX_EDGE_COUNT + 2)
    + 20;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int RANDOM_EDGES  = 30;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [pmvo_pkg::VTX_W-1:0] src;
    logic [pmvo_pkg::VTX_W-1:0] dst;
    logic [pmvo_pkg::WGT_W-1:0] weight;
    logic                       last;
    logic                       hold;
  } edge_txn_t;

  typedef struct packed {
    logic [pmvo_pkg::VTX_W-1:0] vertex;
    logic [pmvo_pkg::WGT_W-1:0] join_weight;
    logic                       last_vertex;
  } tree_step_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_write = 1'b0;
  logic [pmvo_pkg::VTX_W-1:0] cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [pmvo_pkg::VTX_W-1:0] edge_from = '0;
  logic [pmvo_pkg::VTX_W-1:0] edge_to = '0;
  logic [pmvo_pkg::WGT_W-1:0] edge_weight = '0;
  logic                       last_edge = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [pmvo_pkg::VTX_W-1:0] vertex;
  logic [pmvo_pkg::WGT_W-1:0] join_weight;
  logic                       last_vertex;

  edge_txn_t  pending_edges[$];
  tree_step_t tree_expect[$];
  edge_txn_t  cur_edge;
  tree_step_t want;

  logic [pmvo_pkg::VTX_W-1:0] graph_src[pmvo_pkg::MAX_EDGE_COUNT];
  logic [pmvo_pkg::VTX_W-1:0] graph_dst[pmvo_pkg::MAX_EDGE_COUNT];
  logic [pmvo_pkg::WGT_W-1:0] graph_wt[pmvo_pkg::MAX_EDGE_COUNT];
  int                         graph_fill = 0;
  logic [pmvo_pkg::VTX_W-1:0] vcount_model = pmvo_pkg::VCOUNT_RESET;

  int edges_queued = 0;
  int edges_accepted = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int in_gap = 0;
  int stall_left = 0;
  bit in_fire = 1'b0;
  bit in_calm = 1'b0;
  bit out_calm = 1'b0;
  bit next_valid;

  prim_mst_vertex_order dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .edge_from   (edge_from),
    .edge_to     (edge_to),
    .edge_weight (edge_weight),
    .last_edge   (last_edge),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .vertex      (vertex),
    .join_weight (join_weight),
    .last_vertex (last_vertex)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int effective_count(logic [pmvo_pkg::VTX_W-1:0] vc);
    return (vc > pmvo_pkg::MAX_VERTEX_COUNT) ? pmvo_pkg::MAX_VERTEX_COUNT : int'(vc);
  endfunction

  function automatic logic [pmvo_pkg::VTX_W-1:0] pick_end(int eff);
    if (eff == 0 || $urandom_range(0, 9) == 0)
      return pmvo_pkg::VTX_W'($urandom_range(0, 31));
    return pmvo_pkg::VTX_W'($urandom_range(1, eff));
  endfunction

  function automatic logic [pmvo_pkg::WGT_W-1:0] pick_weight();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return pmvo_pkg::WGT_W'($urandom_range(0, 15));
    if (r < 75) return pmvo_pkg::WGT_W'($urandom_range(0, 999));
    if (r < 85) return pmvo_pkg::WGT_W'($urandom_range(990, 1009));
    return pmvo_pkg::WGT_W'($urandom_range(0, 1023));
  endfunction

  // Prim's algorithm from vertex 1 over the stored edges
  task automatic grow_tree();
    int n, u, a, b, other;
    bit found;
    logic [10:0] distance[pmvo_pkg::MAX_VERTEX_COUNT];
    bit taken[pmvo_pkg::MAX_VERTEX_COUNT];
    tree_step_t step;
    n = effective_count(vcount_model);
    for (int i = 0; i < n; i++) begin
      distance[i] = 11'(pmvo_pkg::UNREACHED);
      taken[i] = 1'b0;
    end
    if (n > 0) distance[0] = '0;
    for (int r = 0; r < n; r++) begin
      found = 1'b0;
      u = 0;
      for (int i = 0; i < n; i++) begin
        if (!taken[i] && (!found || distance[i] < distance[u])) begin
          u = i;
          found = 1'b1;
        end
      end
      taken[u] = 1'b1;
      step.vertex = pmvo_pkg::VTX_W'(u + 1);
      step.join_weight = distance[u][pmvo_pkg::WGT_W-1:0];
      step.last_vertex = (r == n - 1);
      tree_expect.push_back(step);
      for (int j = 0; j < graph_fill; j++) begin
        a = int'(graph_src[j]);
        b = int'(graph_dst[j]);
        if (a < 1 || a > n || b < 1 || b > n) continue;
        a--;
        b--;
        if (a != u && b != u) continue;
        other = (a == u) ? b : a;
        if (!taken[other] && graph_wt[j] < distance[other])
          distance[other] = 11'(graph_wt[j]);
      end
    end
    graph_fill = 0;
  endtask

  always @(posedge clk) begin
    in_fire = !rst && in_valid && in_stall === 1'b0;
    if (in_fire) begin
      edges_accepted++;
      if (graph_fill < pmvo_pkg::MAX_EDGE_COUNT) begin
        graph_src[graph_fill] = edge_from;
        graph_dst[graph_fill] = edge_to;
        graph_wt[graph_fill] = edge_weight;
        graph_fill++;
      end
      if (last_edge) grow_tree();
    end
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (tree_expect.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("ERROR: unexpected result vertex=%0d join_weight=%0d last_vertex=%0d",
                   vertex, join_weight, last_vertex);
      end else begin
        want = tree_expect.pop_front();
        if (vertex !== want.vertex || join_weight !== want.join_weight ||
            last_vertex !== want.last_vertex) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("ERROR: expected vertex=%0d join_weight=%0d last_vertex=%0d, got %0d %0d %0d",
                     want.vertex, want.join_weight, want.last_vertex,
                     vertex, join_weight, last_vertex);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      next_valid = 1'b0;
    end else if (in_valid && !in_fire) begin
      next_valid = 1'b1;
    end else if (in_gap > 0) begin
      in_gap--;
      next_valid = 1'b0;
    end else if (pending_edges.size() != 0 &&
                 !(pending_edges[0].hold && tree_expect.size() != 0)) begin
      cur_edge = pending_edges.pop_front();
      edge_from <= cur_edge.src;
      edge_to <= cur_edge.dst;
      edge_weight <= cur_edge.weight;
      last_edge <= cur_edge.last;
      next_valid = 1'b1;
      in_gap = pick_gap(in_calm);
    end else begin
      next_valid = 1'b0;
    end
    if ($urandom_range(0, 47) == 0) in_calm = !in_calm;
    in_valid <= next_valid;
  end

  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) out_calm = !out_calm;
    if (rst) stall_left = 0;
    else if (stall_left == 0 && $urandom_range(0, 2) == 0) stall_left = pick_gap(out_calm);
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic add_edge(int src, int dst, int weight, bit last, bit hold = 1'b0);
    edge_txn_t e;
    e.src = pmvo_pkg::VTX_W'(src);
    e.dst = pmvo_pkg::VTX_W'(dst);
    e.weight = pmvo_pkg::WGT_W'(weight);
    e.last = last;
    e.hold = hold;
    pending_edges.push_back(e);
    edges_queued++;
  endtask

  task automatic wait_idle();
    while (edges_accepted != edges_queued || tree_expect.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_vertex_count(int value);
    wait_idle();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data <= pmvo_pkg::VTX_W'(value);
    @(negedge clk);
    cfg_write <= 1'b0;
    vcount_model = pmvo_pkg::VTX_W'(value);
  endtask

  task automatic random_graph(int n_edges);
    int eff;
    bit hold;
    eff = effective_count(vcount_model);
    hold = ($urandom_range(0, 5) == 0);
    for (int k = 0; k < n_edges; k++)
      add_edge(pick_end(eff), pick_end(eff), pick_weight(), k == n_edges - 1, hold && k == 0);
  endtask

  initial begin
    int r, vc, k, random_edges;
    random_edges = 0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    add_edge(1, 2, 5, 0);
    add_edge(1, 3, 5, 0);
    add_edge(2, 3, 0, 0);
    add_edge(3, 4, 1023, 0);
    add_edge(4, 5, 999, 0);
    add_edge(5, 5, 7, 0);
    add_edge(0, 6, 3, 0);
    add_edge(6, 11, 3, 0);
    add_edge(31, 2, 1, 0);
    add_edge(7, 8, 1000, 0);
    add_edge(1, 7, 2, 0);
    add_edge(8, 9, 500, 0);
    add_edge(9, 10, 600, 0);
    add_edge(10, 1, 700, 1);
    add_edge(16, 16, 0, 1, 1);

    set_vertex_count(16);
    add_edge(16, 1, 1023, 0);
    add_edge(15, 16, 512, 0);
    add_edge(1, 15, 1, 1);
    set_vertex_count(1);
    add_edge(1, 1, 0, 1);
    set_vertex_count(0);
    add_edge(1, 2, 3, 1);
    set_vertex_count(31);
    add_edge(1, 16, 100, 1);
    set_vertex_count(17);
    add_edge(2, 17, 4, 0);
    add_edge(17, 1, 5, 0);
    add_edge(1, 2, 9, 1);

    while (random_edges < RANDOM_EDGES) begin
      r = $urandom_range(0, 11);
      vc = (r == 0) ? 0 : (r == 1) ? $urandom_range(17, 31) : (r == 2) ? 1 :
           $urandom_range(2, 16);
      set_vertex_count(vc);
      repeat ($urandom_range(3, 6)) begin
        k = $urandom_range(1, 14);
        random_graph(k);
        random_edges += k;
      end
    end

    // fill the edge store, then drop cheap edges that would change the tree
    set_vertex_count(pmvo_pkg::MAX_VERTEX_COUNT);
    for (int i = 0; i < pmvo_pkg::MAX_EDGE_COUNT; i++)
      add_edge($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(20, 1023), 0);
    add_edge(1, 2, 0, 0);
    add_edge(2, 3, 0, 0);
    add_edge(1, 16, 0, 1);

    wait_idle();
    if (mismatches == 0 && tree_expect.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: prim_mst_vertex_order.f
rtl/pmvo_pkg.sv
rtl/pmvo_ctrl.sv
rtl/pmvo_dpath.sv
rtl/prim_mst_vertex_order.sv
tb/tb_prim_mst_vertex_order.sv
